// File: sv/mavg_pkg.sv
// Shared constants for the multichannel ADC moving average scaler.
// Holds configuration register indexes, reset values and parameter defaults.
// No dependencies.
package mavg_pkg;

    localparam int CHANNELS_DEF    = 2;
    localparam int WINDOW_DEF      = 20;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACTIVE = 3'd0,
        CFG_ABS    = 3'd1,
        CFG_GAIN0  = 3'd2,
        CFG_OFF0   = 3'd3,
        CFG_GAIN1  = 3'd4,
        CFG_OFF1   = 3'd5
    } t_cfg_idx;

    localparam logic [1:0]  ACTIVE_RESET = 2'd2;
    localparam logic [1:0]  ABS_RESET    = 2'd0;
    localparam logic [31:0] GAIN_RESET   = 32'd13517;
    localparam logic [31:0] OFF_RESET    = 32'd0;

endpackage

// File: sv/mavg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mavg_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/multichannel_adc_moving_average_scaler_unit.sv
// Top level of the multichannel ADC moving average scaler.
// Depends on mavg_pkg and mavg_ram.
// Usage:
//   Slave stream: s_axis_tuser is the channel, s_axis_tdata holds the raw
//   converter sample. Samples for a channel that is not active are dropped
//   with no result. Each active sample yields one master transaction with
//   the raw sample, its scaled value, the boxcar window mean, the scaled mean
//   and the channel's sample count.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_addr;
//   unknown indexes are ignored. The user writes only while the block is idle;
//   the block itself does not enforce this.
//   Processing: each sample goes through the state and window memory reads,
//   the bit-per-cycle restoring divider that forms the mean and the shared
//   multiplier used twice. The next sample is taken the cycle after the result
//   is loaded into the output register.
//   Reset: configuration returns to its reset values, all per-channel sums,
//   indexes, fill counts and sample counters read as zero at once.
//   Stall: a result waits in the output register while m_axis_tready is low;
//   a following sample is processed and holds in its final step until the
//   output register is free.
module multichannel_adc_moving_average_scaler_unit #(
    parameter int CHANNELS    = mavg_pkg::CHANNELS_DEF,
    parameter int WINDOW      = mavg_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF,
    localparam int ITW = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OTW = ((2 * SAMPLE_BITS + 96 + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ITW-1:0]                  s_axis_tdata,  // sample
    input  logic                            s_axis_tuser,  // channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // raw_latest, scaled_latest, mean_raw, scaled_mean, sample_count
    output logic [OTW-1:0]                  m_axis_tdata,
    output logic                            m_axis_tuser,  // out_channel
    input  logic                            i_cfg_we,
    input  logic [mavg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mavg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW  = $clog2(WINDOW + 1);
    localparam int SW  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int WD  = CHANNELS * WINDOW;
    localparam int AW  = (WD > 1) ? $clog2(WD) : 1;
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STW = SW + IW + FW + 32;
    localparam int PW  = SAMPLE_BITS + 33;
    localparam int QW  = PW - 6;
    localparam int DCW = $clog2(SW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDST,
        ST_RDWIN,
        ST_DIV,
        ST_MULR,
        ST_MULM,
        ST_OUT
    } t_state;

    // configuration
    logic [1:0]  r_active;
    logic [1:0]  r_abs;
    logic [31:0] r_gain [2];
    logic [31:0] r_off  [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= mavg_pkg::ACTIVE_RESET;
            r_abs    <= mavg_pkg::ABS_RESET;
            r_gain[0] <= mavg_pkg::GAIN_RESET;
            r_gain[1] <= mavg_pkg::GAIN_RESET;
            r_off[0]  <= mavg_pkg::OFF_RESET;
            r_off[1]  <= mavg_pkg::OFF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mavg_pkg::CFG_ACTIVE: r_active  <= i_cfg_data[1:0];
                mavg_pkg::CFG_ABS:    r_abs     <= i_cfg_data[1:0];
                mavg_pkg::CFG_GAIN0:  r_gain[0] <= i_cfg_data;
                mavg_pkg::CFG_OFF0:   r_off[0]  <= i_cfg_data;
                mavg_pkg::CFG_GAIN1:  r_gain[1] <= i_cfg_data;
                mavg_pkg::CFG_OFF1:   r_off[1]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state                 r_state;
    logic                   r_ch;
    logic [SAMPLE_BITS-1:0] r_raw;
    logic [SW-1:0]          r_sum;
    logic [IW-1:0]          r_idx;
    logic [FW-1:0]          r_fill;
    logic [31:0]            r_cnt;
    logic [AW-1:0]          r_waddr;
    logic [CHANNELS-1:0]    r_vld;
    logic [SW-1:0]          r_dvd;
    logic [FW-1:0]          r_rem;
    logic [DCW-1:0]         r_dcnt;
    logic signed [PW-1:0]   r_prod;
    logic [31:0]            r_scl_raw;

    logic                   r_o_valid;
    logic                   r_o_ch;
    logic [SAMPLE_BITS-1:0] r_o_raw;
    logic [31:0]            r_o_scl;
    logic [SAMPLE_BITS-1:0] r_o_mean;
    logic [31:0]            r_o_mscl;
    logic [31:0]            r_o_cnt;

    logic                   w_in_ch;
    logic [SAMPLE_BITS-1:0] w_in_raw;
    logic                   w_accept;
    logic                   w_act;

    logic [STW-1:0]         w_st_rdata;
    logic [STW-1:0]         w_st_cur;
    logic [SW-1:0]          w_sum;
    logic [IW-1:0]          w_idx;
    logic [FW-1:0]          w_fill;
    logic [31:0]            w_cnt;
    logic [AW-1:0]          w_base;
    logic [AW-1:0]          w_win_addr;
    logic [SAMPLE_BITS-1:0] w_old;

    logic                   w_full;
    logic [SW-1:0]          n_sum;
    logic [IW-1:0]          n_idx;
    logic [FW-1:0]          n_fill;
    logic [31:0]            n_cnt;
    logic                   w_wr;

    logic [FW:0]            w_trial;
    logic                   w_qbit;
    logic [FW-1:0]          n_rem;

    logic signed [31:0]     w_gain;
    logic signed [PW-9:0]   w_shr;
    logic signed [QW-1:0]   w_q;
    logic signed [QW-1:0]   w_qa;
    logic [31:0]            w_post;
    logic                   w_fits;
    logic                   w_out_free;

    assign w_in_ch  = s_axis_tuser;
    assign w_in_raw = s_axis_tdata[SAMPLE_BITS-1:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_act    = ({1'b0, w_in_ch} < r_active) && ((CHANNELS > 1) || !w_in_ch);

    // per-channel state: entries that were never written read as zero
    assign w_st_cur = r_vld[r_ch] ? w_st_rdata : '0;
    assign w_sum    = w_st_cur[SW-1:0];
    assign w_idx    = w_st_cur[SW +: IW];
    assign w_fill   = w_st_cur[SW+IW +: FW];
    assign w_cnt    = w_st_cur[SW+IW+FW +: 32];
    assign w_base   = r_ch ? AW'(WINDOW) : '0;
    assign w_win_addr = w_base + AW'(w_idx);

    always_comb begin
        w_full = (r_fill == FW'(WINDOW));
        n_sum  = w_full ? (r_sum - SW'(w_old) + SW'(r_raw)) : (r_sum + SW'(r_raw));
        n_fill = w_full ? r_fill : (r_fill + FW'(1));
        n_idx  = (r_idx == IW'(WINDOW - 1)) ? '0 : (r_idx + IW'(1));
        n_cnt  = r_cnt + 32'd1;
    end

    assign w_wr = (r_state == ST_RDWIN);

    mavg_ram #(
        .WIDTH(STW),
        .DEPTH(CHANNELS)
    ) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr),
        .i_waddr(CW'(r_ch)),
        .i_wdata({n_cnt, n_fill, n_idx, n_sum}),
        .i_raddr(CW'(w_in_ch)),
        .o_rdata(w_st_rdata)
    );

    mavg_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(WD)
    ) u_win_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr),
        .i_waddr(r_waddr),
        .i_wdata(r_raw),
        .i_raddr(w_win_addr),
        .o_rdata(w_old)
    );

    // restoring divide step
    always_comb begin
        w_trial = {r_rem, r_dvd[SW-1]};
        w_qbit  = (w_trial >= {1'b0, r_fill});
        n_rem   = w_qbit ? FW'(w_trial - {1'b0, r_fill}) : FW'(w_trial);
    end

    // floor to Q16.16, offset, optional fold, saturate
    always_comb begin
        w_gain = $signed(r_gain[r_ch]);
        w_shr  = r_prod[PW-1:8];
        w_q    = $signed({{2{w_shr[PW-9]}}, w_shr})
               + $signed({{(QW-32){r_off[r_ch][31]}}, r_off[r_ch]});
        w_qa   = (r_abs[r_ch] && w_q[QW-1]) ? -w_q : w_q;
        w_fits = (w_qa[QW-1:31] == '0) || (w_qa[QW-1:31] == '1);
        if (w_fits) begin
            w_post = w_qa[31:0];
        end else if (w_qa[QW-1]) begin
            w_post = 32'h8000_0000;
        end else begin
            w_post = 32'h7FFF_FFFF;
        end
    end

    assign w_out_free = !r_o_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_act) begin
                        r_ch    <= w_in_ch;
                        r_raw   <= w_in_raw;
                        r_state <= ST_RDST;
                    end
                end
                ST_RDST: begin
                    r_sum   <= w_sum;
                    r_idx   <= w_idx;
                    r_fill  <= w_fill;
                    r_cnt   <= w_cnt;
                    r_waddr <= w_win_addr;
                    r_state <= ST_RDWIN;
                end
                ST_RDWIN: begin
                    r_vld[r_ch] <= 1'b1;
                    r_cnt   <= n_cnt;
                    r_fill  <= n_fill;
                    r_dvd   <= n_sum;
                    r_rem   <= '0;
                    r_dcnt  <= DCW'(SW);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[SW-2:0], w_qbit};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= ST_MULR;
                    end
                end
                ST_MULR: begin
                    r_prod  <= $signed({1'b0, r_raw}) * w_gain;
                    r_state <= ST_MULM;
                end
                ST_MULM: begin
                    r_scl_raw <= w_post;
                    r_prod    <= $signed({1'b0, r_dvd[SAMPLE_BITS-1:0]}) * w_gain;
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ch    <= r_ch;
                        r_o_raw   <= r_raw;
                        r_o_scl   <= r_scl_raw;
                        r_o_mean  <= r_dvd[SAMPLE_BITS-1:0];
                        r_o_mscl  <= w_post;
                        r_o_cnt   <= r_cnt;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_ch;
    assign m_axis_tdata  = OTW'({r_o_cnt, r_o_mscl, r_o_mean, r_o_scl, r_o_raw});

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWIN) |-> (n_fill != '0) && (n_fill <= FW'(WINDOW)))
        else $error("window fill out of range");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_fill != '0))
        else $error("divide by zero fill");

    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MULR) |-> ((r_dvd >> SAMPLE_BITS) == '0))
        else $error("window mean exceeds sample range");

    a_win_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDWIN) |-> (int'(r_waddr) < WD))
        else $error("window address out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_act) |=> !s_axis_tready)
        else $error("new sample taken while one is in work");
`endif

endmodule

// File: test/multichannel_adc_moving_average_scaler_unit_test.sv
// Self-checking bench for the multichannel ADC moving average scaler.
// Predicts each result from a boxcar window model and drives both streams with random stalls.
// Depends on mavg_pkg and the multichannel_adc_moving_average_scaler_unit RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic        ch;
    logic [11:0] raw;
    logic [31:0] scaled;
    logic [11:0] mean;
    logic [31:0] scaled_mean;
    logic [31:0] count;
} t_adc_result;

class adc_mean_board;
    logic [1:0]  active_ch;
    logic [1:0]  abs_bits;
    logic [31:0] gain [2];
    logic [31:0] offset [2];
    logic [11:0] window [2][mavg_pkg::WINDOW_DEF];
    int unsigned win_sum [2];
    int unsigned wr_pos [2];
    int unsigned fill [2];
    logic [31:0] seen [2];
    t_adc_result pending_results [$];
    int          errors;

    function new();
        active_ch = mavg_pkg::ACTIVE_RESET;
        abs_bits  = mavg_pkg::ABS_RESET;
        for (int c = 0; c < 2; c++) begin
            gain[c]    = mavg_pkg::GAIN_RESET;
            offset[c]  = mavg_pkg::OFF_RESET;
            win_sum[c] = 0;
            wr_pos[c]  = 0;
            fill[c]    = 0;
            seen[c]    = '0;
        end
        errors = 0;
    endfunction

    function void write_reg(logic [mavg_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
        case (idx)
            mavg_pkg::CFG_ACTIVE: active_ch = val[1:0];
            mavg_pkg::CFG_ABS:    abs_bits = val[1:0];
            mavg_pkg::CFG_GAIN0:  gain[0] = val;
            mavg_pkg::CFG_OFF0:   offset[0] = val;
            mavg_pkg::CFG_GAIN1:  gain[1] = val;
            mavg_pkg::CFG_OFF1:   offset[1] = val;
            default: ;
        endcase
    endfunction

    function logic [31:0] scale_value(logic [11:0] raw, bit ch);
        longint prod;
        longint q;
        prod = longint'($signed({1'b0, raw})) * longint'($signed(gain[ch]));
        q = prod >>> 8;
        q = q + longint'($signed(offset[ch]));
        if (abs_bits[ch] && q < 0)
            q = -q;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // Returns 1 when the sample yields a result.
    function bit note_sample(bit ch, logic [11:0] raw);
        t_adc_result r;
        int unsigned mean;
        if (ch >= active_ch || ch >= mavg_pkg::CHANNELS_DEF)
            return 0;
        seen[ch] = seen[ch] + 1;
        if (fill[ch] < mavg_pkg::WINDOW_DEF) begin
            win_sum[ch] += raw;
            fill[ch] += 1;
        end else begin
            win_sum[ch] -= window[ch][wr_pos[ch]];
            win_sum[ch] += raw;
        end
        window[ch][wr_pos[ch]] = raw;
        wr_pos[ch] = (wr_pos[ch] + 1) % mavg_pkg::WINDOW_DEF;
        mean = win_sum[ch] / fill[ch];
        r.ch          = ch;
        r.raw         = raw;
        r.scaled      = scale_value(raw, ch);
        r.mean        = mean[11:0];
        r.scaled_mean = scale_value(mean[11:0], ch);
        r.count       = seen[ch];
        pending_results.push_back(r);
        return 1;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(logic ch, logic [119:0] d);
        t_adc_result e;
        if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none, actual channel %0d data %h",
                     $time, ch, d);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        compare_field("out_channel", 32'(e.ch), 32'(ch));
        compare_field("raw_latest", 32'(e.raw), 32'(d[11:0]));
        compare_field("scaled_latest", e.scaled, d[43:12]);
        compare_field("mean_raw", 32'(e.mean), 32'(d[55:44]));
        compare_field("scaled_mean", e.scaled_mean, d[87:56]);
        compare_field("sample_count", e.count, d[119:88]);
    endfunction

    function int pending();
        return pending_results.size();
    endfunction
endclass

module multichannel_adc_moving_average_scaler_unit_test;

    localparam logic [mavg_pkg::CFG_ADDR_W-1:0] CFG_SPARE0 = 3'd6;
    localparam logic [mavg_pkg::CFG_ADDR_W-1:0] CFG_SPARE1 = 3'd7;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 11;
    localparam int PHASE_RESULTS = 50;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [119:0]                    m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            i_cfg_we;
    logic [mavg_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [mavg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    adc_mean_board sb = new();
    bit            tx_idle_on;
    bit            rx_idle_on;
    int            cycle_count;

    multichannel_adc_moving_average_scaler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    task automatic send_sample(input bit ch, input logic [11:0] smp, output bit produced);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ch;
        s_axis_tdata  <= {4'b0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        produced = sb.note_sample(ch, smp);
    endtask

    task automatic send_list(input logic [12:0] items [$]);
        bit produced;
        foreach (items[k])
            send_sample(items[k][12], items[k][11:0], produced);
    endtask

    // Hold the sender until every result is out, then let ignored samples finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mavg_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 6))
            0: w = 32'h8000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'h0;
            3: w = $urandom;
            4: w = mavg_pkg::GAIN_RESET;
            default: begin
                w = $urandom_range(0, 40000);
                if ($urandom_range(0, 1) == 1)
                    w = -w;
            end
        endcase
        return w;
    endfunction

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin
        int          produced_cnt;
        bit          produced;
        logic [1:0]  act;
        int          r;

        cycle_count   <= 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_list('{{1'b0, 12'h000}, {1'b0, 12'hFFF}, {1'b1, 12'hFFF}, {1'b1, 12'h000},
                    {1'b0, 12'hAAA}, {1'b1, 12'h555}});
        drain();
        // single active channel: drop channel 1
        write_reg(mavg_pkg::CFG_ACTIVE, 32'd1);
        send_list('{{1'b1, 12'd100}, {1'b0, 12'd7}, {1'b1, 12'd200}});
        drain();
        write_reg(mavg_pkg::CFG_ACTIVE, 32'd0);
        send_list('{{1'b0, 12'd1}, {1'b1, 12'd2}});
        drain();
        write_reg(mavg_pkg::CFG_ACTIVE, 32'd3);
        send_list('{{1'b1, 12'd3}, {1'b0, 12'd4}});
        drain();
        // saturate with absolute value folding
        write_reg(mavg_pkg::CFG_ABS, 32'd3);
        write_reg(mavg_pkg::CFG_GAIN0, 32'h8000_0000);
        write_reg(mavg_pkg::CFG_OFF0, 32'h8000_0000);
        write_reg(mavg_pkg::CFG_GAIN1, 32'h7FFF_FFFF);
        write_reg(mavg_pkg::CFG_OFF1, 32'h7FFF_FFFF);
        write_reg(CFG_SPARE0, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE1, 32'h0);
        send_list('{{1'b0, 12'hFFF}, {1'b0, 12'h000}, {1'b1, 12'hFFF}, {1'b1, 12'h001}});
        drain();
        write_reg(mavg_pkg::CFG_ABS, 32'd0);
        write_reg(mavg_pkg::CFG_OFF0, 32'h7FFF_FFFF);
        write_reg(mavg_pkg::CFG_OFF1, 32'h8000_0000);
        send_list('{{1'b0, 12'hFFF}, {1'b1, 12'hFFF}, {1'b0, 12'h800}, {1'b1, 12'h800}});

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            tx_idle_on = !(ph == 4 || ph >= PHASES - 2);
            rx_idle_on = tx_idle_on;
            r = $urandom_range(0, 9);
            act = (r == 0) ? 2'd0 : (r == 1) ? 2'd1 : (r == 2) ? 2'd3 : 2'd2;
            if (ph >= PHASES - 2)
                act = 2'd2;
            write_reg(mavg_pkg::CFG_ACTIVE, 32'(act));
            write_reg(mavg_pkg::CFG_ABS, 32'($urandom_range(0, 3)));
            write_reg(mavg_pkg::CFG_GAIN0, pick_word());
            write_reg(mavg_pkg::CFG_OFF0, pick_word());
            write_reg(mavg_pkg::CFG_GAIN1, pick_word());
            write_reg(mavg_pkg::CFG_OFF1, pick_word());
            if (act == 2'd0) begin
                repeat (8) send_sample($urandom_range(0, 1), pick_sample(), produced);
            end else begin
                produced_cnt = 0;
                while (produced_cnt < PHASE_RESULTS) begin
                    send_sample($urandom_range(0, 1), pick_sample(), produced);
                    if (produced)
                        produced_cnt++;
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
sv/mavg_pkg.sv
sv/mavg_ram.sv
sv/multichannel_adc_moving_average_scaler_unit.sv
test/multichannel_adc_moving_average_scaler_unit_test.sv
